FILE: design/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [33:0] HALF_Q16 = 34'h08000;

  // hexcone sectors, hue times six, integer part
  localparam logic [2:0] SECT_RED_YEL = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG = 3'd4;
  localparam logic [2:0] SECT_MAG_RED = 3'd5;

  // after clamping and hue split
  typedef struct packed {
    logic        grey;
    logic [2:0]  sector;
    logic [15:0] frac;
    logic [16:0] v;
    logic [16:0] s;
    logic [16:0] alpha;
  } front_t;

  // after first multiplier row
  typedef struct packed {
    logic        grey;
    logic [2:0]  sector;
    logic [16:0] v;
    logic [16:0] p;
    logic [16:0] sf;
    logic [16:0] snf;
    logic [16:0] alpha;
  } ramp1_t;

  // after second multiplier row
  typedef struct packed {
    logic        grey;
    logic [2:0]  sector;
    logic [16:0] v;
    logic [16:0] p;
    logic [16:0] q;
    logic [16:0] t;
    logic [16:0] alpha;
  } ramp2_t;

  typedef struct packed {
    logic [16:0] alpha;
    logic [16:0] blue;
    logic [16:0] green;
    logic [16:0] red;
  } pixel_t;

  // Q.16 product, round to nearest, ties up; operands never exceed 1.0
  function automatic logic [16:0] mul_q16(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] prod;
    prod = 34'(a) * 34'(b) + HALF_Q16;
    return prod[32:16];
  endfunction

endpackage

`default_nettype wire

FILE: design/hsv_to_rgb_converter.sv
// Pipeline: four register stages (clamp, two multiplier rows, sector mux); a word accepted
//   at the input is registered in each stage in that order before out_tvalid presents it.
// Throughput: one word per clock; each stage holds one word and advances whenever the next
//   stage is empty or moving, so a stall on out_tready backs up without loss or repeat.
// Reset: rst_n synchronous, active low, clears the stage valid bits only; no other state.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // slave side
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // hue[15:0], sat[33:16], value_level[51:34],
                                       // alpha_in[68:52], zero pad [71:69]
  // master side
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // red[16:0], green[33:17], blue[50:34],
                                       // alpha_out[67:51], zero pad [71:68]
);

  logic [15:0]        hue;
  logic signed [17:0] sat;
  logic signed [17:0] value_level;
  logic [16:0]        alpha_in;

  logic   fr_valid;
  logic   fr_ready;
  front_t fr_data;
  logic   rp_valid;
  logic   rp_ready;
  ramp2_t rp_data;
  pixel_t pix;

  assign hue         = in_tdata[15:0];
  assign sat         = in_tdata[33:16];
  assign value_level = in_tdata[51:34];
  assign alpha_in    = in_tdata[68:52];

  // stage 1: clamp v and s, grey flag, hue * 6 into sector and ramp fraction
  hsv2rgb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .hue         (hue),
    .sat         (sat),
    .value_level (value_level),
    .alpha_in    (alpha_in),
    .out_valid   (fr_valid),
    .out_ready   (fr_ready),
    .out_data    (fr_data)
  );

  // stages 2-3: p, q, t through two rows of 17x17 rounded multiplies
  hsv2rgb_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (rp_valid),
    .out_ready (rp_ready),
    .out_data  (rp_data)
  );

  // stage 4: sector routing / grey override into the output register
  hsv2rgb_mux u_mux (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rp_valid),
    .in_ready  (rp_ready),
    .in_data   (rp_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (pix)
  );

  assign out_tdata = {4'b0000, pix.alpha, pix.blue, pix.green, pix.red};

  // input backs up only when every stage is full and the output is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output stall");
  a_rgb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pix.red <= ONE_Q16 && pix.green <= ONE_Q16 && pix.blue <= ONE_Q16))
    else $error("color channel above one");

endmodule

`default_nettype wire

FILE: design/hsv2rgb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_front
  import hsv2rgb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        hue,
  input  wire logic signed [17:0] sat,
  input  wire logic signed [17:0] value_level,
  input  wire logic [16:0]        alpha_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output front_t                  out_data
);

  logic        valid_r;
  front_t      data_r;
  front_t      data_nxt;
  logic [18:0] h6;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    h6 = 19'(hue) * 19'd6;
    data_nxt.sector = h6[18:16];
    data_nxt.frac   = h6[15:0];
    data_nxt.grey   = sat[17] || (sat == 18'sd0);
    if (value_level[17]) begin
      data_nxt.v = '0;
    end else if (value_level > 18'sd65536) begin
      data_nxt.v = ONE_Q16;
    end else begin
      data_nxt.v = value_level[16:0];
    end
    // only meaningful when not grey
    if (sat > 18'sd65536) begin
      data_nxt.s = ONE_Q16;
    end else begin
      data_nxt.s = sat[16:0];
    end
    data_nxt.alpha = alpha_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: design/hsv2rgb_ramp.sv
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_ramp
  import hsv2rgb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire front_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output ramp2_t      out_data
);

  logic   m1_valid_r;
  ramp1_t m1_r;
  ramp1_t m1_nxt;
  logic   m1_ready;
  logic   m2_valid_r;
  ramp2_t m2_r;
  ramp2_t m2_nxt;

  assign m1_ready = !m2_valid_r || out_ready;
  assign in_ready = !m1_valid_r || m1_ready;

  // row 1: s*f, s*(1-f), v*(1-s)
  always_comb begin
    m1_nxt.grey   = in_data.grey;
    m1_nxt.sector = in_data.sector;
    m1_nxt.v      = in_data.v;
    m1_nxt.alpha  = in_data.alpha;
    m1_nxt.sf     = mul_q16(in_data.s, {1'b0, in_data.frac});
    m1_nxt.snf    = mul_q16(in_data.s, ONE_Q16 - {1'b0, in_data.frac});
    m1_nxt.p      = mul_q16(in_data.v, ONE_Q16 - in_data.s);
  end

  // row 2: falling and rising ramps
  always_comb begin
    m2_nxt.grey   = m1_r.grey;
    m2_nxt.sector = m1_r.sector;
    m2_nxt.v      = m1_r.v;
    m2_nxt.alpha  = m1_r.alpha;
    m2_nxt.p      = m1_r.p;
    m2_nxt.q      = mul_q16(m1_r.v, ONE_Q16 - m1_r.sf);
    m2_nxt.t      = mul_q16(m1_r.v, ONE_Q16 - m1_r.snf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        m1_valid_r <= in_valid;
      end
      if (m1_ready) begin
        m2_valid_r <= m1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m1_r <= m1_nxt;
    end
    if (m1_ready && m1_valid_r) begin
      m2_r <= m2_nxt;
    end
  end

  assign out_valid = m2_valid_r;
  assign out_data  = m2_r;

  // ramps never rise above brightness when saturation is positive
  a_p_le_v: assert property (@(posedge clk) disable iff (!rst_n)
    (m1_valid_r && !m1_r.grey) |-> (m1_r.p <= m1_r.v))
    else $error("p above v");
  a_qt_le_v: assert property (@(posedge clk) disable iff (!rst_n)
    (m2_valid_r && !m2_r.grey) |-> (m2_r.q <= m2_r.v && m2_r.t <= m2_r.v))
    else $error("q or t above v");

endmodule

`default_nettype wire

FILE: design/hsv2rgb_mux.sv
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_mux
  import hsv2rgb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire ramp2_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output pixel_t      out_data
);

  logic   valid_r;
  pixel_t pix_r;
  pixel_t pix_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    pix_nxt.alpha = in_data.alpha;
    if (in_data.grey) begin
      pix_nxt.red   = in_data.v;
      pix_nxt.green = in_data.v;
      pix_nxt.blue  = in_data.v;
    end else begin
      unique case (in_data.sector)
        SECT_RED_YEL: begin
          pix_nxt.red = in_data.v; pix_nxt.green = in_data.t; pix_nxt.blue = in_data.p;
        end
        SECT_YEL_GRN: begin
          pix_nxt.red = in_data.q; pix_nxt.green = in_data.v; pix_nxt.blue = in_data.p;
        end
        SECT_GRN_CYN: begin
          pix_nxt.red = in_data.p; pix_nxt.green = in_data.v; pix_nxt.blue = in_data.t;
        end
        SECT_CYN_BLU: begin
          pix_nxt.red = in_data.p; pix_nxt.green = in_data.q; pix_nxt.blue = in_data.v;
        end
        SECT_BLU_MAG: begin
          pix_nxt.red = in_data.t; pix_nxt.green = in_data.p; pix_nxt.blue = in_data.v;
        end
        default: begin
          pix_nxt.red = in_data.v; pix_nxt.green = in_data.p; pix_nxt.blue = in_data.q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = pix_r;

  // hexcone: brightness always lands on at least one channel
  a_v_present: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (pix_r.red == $past(in_data.v) ||
      pix_r.green == $past(in_data.v) || pix_r.blue == $past(in_data.v)))
    else $error("no channel carries brightness");

endmodule

`default_nettype wire
